@@ src/ppm_pkg.sv @@
// Package for the path prefix permission matcher: sizes, codes, shared types.
// No dependencies; the other files that use it refer to it by scoped names.
package ppm_pkg;

  localparam int unsigned NUM_ENTRIES = 16;
  localparam int unsigned ENTRY_LEN   = 64;

  localparam int unsigned POS_W  = $clog2(ENTRY_LEN + 1);
  localparam int unsigned ADDR_W = $clog2(ENTRY_LEN);
  localparam int unsigned CNT_W  = $clog2(NUM_ENTRIES + 1);
  localparam int unsigned EIDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;

  localparam logic [7:0] SLASH = 8'h2F;
  localparam logic [7:0] NUL   = 8'h00;

  // Input function codes
  localparam logic [1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [1:0] FUNC_UNVEIL = 2'd1;
  localparam logic [1:0] FUNC_LOCK   = 2'd2;
  localparam logic [1:0] FUNC_CHECK  = 2'd3;

  // Result kinds and codes
  localparam logic       KIND_UNVEIL = 1'b0;
  localparam logic       KIND_CHECK  = 1'b1;
  localparam logic [1:0] RES_ADDED   = 2'd0;
  localparam logic [1:0] RES_LOCKED  = 2'd1;
  localparam logic [1:0] RES_FULL    = 2'd2;
  localparam logic [1:0] RES_ALLOW   = 2'd0;
  localparam logic [1:0] RES_DENY    = 2'd1;
  localparam logic [1:0] RES_HIDDEN  = 2'd2;

  typedef enum logic [2:0] {
    CLS_CLEAR,
    CLS_LOCK,
    CLS_UBYTE,
    CLS_UTERM,
    CLS_CBYTE,
    CLS_CTERM
  } cls_e;

  typedef struct packed {
    cls_e       cls;
    logic [7:0] ch;
    logic [7:0] bits;
  } item_t;

endpackage

@@ src/ppm_if.sv @@
// Channel interfaces of the path prefix permission matcher.
// Depends on nothing; valid/ready handshake with payload.
interface ppm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] ch;
  logic [7:0] access_bits;
  modport source (output valid, output func, output ch, output access_bits, input ready);
  modport sink   (input valid, input func, input ch, input access_bits, output ready);
endinterface

interface ppm_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [1:0] code;
  modport source (output valid, output kind, output code, input ready);
  modport sink   (input valid, input kind, input code, output ready);
endinterface

@@ src/path_prefix_permission_matcher_core.sv @@
// Top level of the path prefix permission matcher.
// Depends on ppm_pkg, ppm_if, ppm_front, ppm_back (and ppm_ram below it).
//
// Usage:
//   in_i carries one byte per transaction: func (clear, unveil byte, lock,
//   check byte), ch and access_bits. A zero ch ends an unveil or check
//   string; only terminators produce a transaction on out_o (kind, code).
//   Front: a two-entry queue classifies and holds incoming transactions.
//   Back: processes one queued item at a time against the prefix table,
//   whose bytes sit in one RAM per entry read at a shared address.
//   Clear, lock and unveil bytes and check terminators need no RAM read; a
//   check byte takes a RAM read, then a parallel compare of all entries;
//   an unveil terminator of a new non-empty prefix takes a RAM read of
//   its last byte. The RAM read port sets these steps.
//   Reset empties the table, unlocks it and restarts any string; no
//   clearing pass is needed. A stalled out_o holds its result; the back part
//   waits only when it must deliver a new one, and the queue keeps taking
//   input until it is full.
module path_prefix_permission_matcher_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  ppm_in_if.sink     in_i,
  ppm_out_if.source  out_o
);

  logic           item_valid;
  ppm_pkg::item_t item;
  logic           pop;

  ppm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .pop_i        (pop)
  );

  ppm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .pop_o        (pop),
    .out_o        (out_o)
  );

endmodule

@@ src/ppm_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ppm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/ppm_front.sv @@
// Front part: accepts input transactions, classifies them, queues them.
// Depends on ppm_pkg and ppm_in_if.
module ppm_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  ppm_in_if.sink        in_i,
  output logic          item_valid_o,
  output ppm_pkg::item_t item_o,
  input  logic          pop_i
);

  ppm_pkg::item_t fifo_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     fill_q, fill_d;
  ppm_pkg::item_t cls_item;
  logic           push, pop;

  // Classify the incoming byte
  always_comb begin
    cls_item.ch   = in_i.ch;
    cls_item.bits = in_i.access_bits;
    unique case (in_i.func)
      ppm_pkg::FUNC_CLEAR:  cls_item.cls = ppm_pkg::CLS_CLEAR;
      ppm_pkg::FUNC_LOCK:   cls_item.cls = ppm_pkg::CLS_LOCK;
      ppm_pkg::FUNC_UNVEIL: cls_item.cls = (in_i.ch == ppm_pkg::NUL) ?
                                           ppm_pkg::CLS_UTERM : ppm_pkg::CLS_UBYTE;
      default:              cls_item.cls = (in_i.ch == ppm_pkg::NUL) ?
                                           ppm_pkg::CLS_CTERM : ppm_pkg::CLS_CBYTE;
    endcase
  end

  assign in_i.ready   = (fill_q != 2'd2);
  assign push         = in_i.valid && in_i.ready;
  assign pop          = pop_i && (fill_q != 2'd0);
  assign item_valid_o = (fill_q != 2'd0);
  assign item_o       = fifo_q[rd_ptr_q];

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Store queued payload
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cls_item;
    end
  end

endmodule

@@ src/ppm_back.sv @@
// Back part: prefix table, per-entry byte RAMs, match state, result register.
// Depends on ppm_pkg, ppm_ram and ppm_out_if.
module ppm_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           item_valid_i,
  input  ppm_pkg::item_t item_i,
  output logic           pop_o,
  ppm_out_if.source      out_o
);

  localparam int unsigned N  = ppm_pkg::NUM_ENTRIES;
  localparam int unsigned L  = ppm_pkg::ENTRY_LEN;
  localparam int unsigned PW = ppm_pkg::POS_W;
  localparam int unsigned AW = ppm_pkg::ADDR_W;
  localparam int unsigned CW = ppm_pkg::CNT_W;
  localparam int unsigned EW = ppm_pkg::EIDX_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CHK  = 2'd1;
  localparam logic [1:0] ST_TERM = 2'd2;

  logic [1:0]    state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic          locked_q, locked_d;
  logic [PW-1:0] pos_q, pos_d, pos_inc;
  logic [N-1:0]  match_q, match_d;
  logic [N-1:0]  slash_q, slash_d;
  logic [7:0]    ch_q, ch_d;
  logic [7:0]    perms_in_q, perms_in_d;
  logic [AW-1:0] len_q, len_d, len_c;

  logic [AW-1:0] plen_q  [N];
  logic [7:0]    perms_q [N];
  logic [N-1:0]  eslash_q;
  logic          commit;
  logic          commit_eslash;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_rdata [N];

  logic          ovalid_q, okind_q;
  logic [1:0]    ocode_q;
  logic          emit, emit_kind;
  logic [1:0]    emit_code;
  logic          out_free;
  logic [1:0]    verdict;
  logic          found;

  // Per-entry prefix byte memories, all read at one shared address
  for (genvar g = 0; g < N; g++) begin : g_ram
    ppm_ram #(.Width(8), .Depth(L)) u_ram (
      .clk_i   (clk_i),
      .we_i    (ram_we && (count_q == CW'(g))),
      .waddr_i (ram_waddr),
      .wdata_i (item_i.ch),
      .re_i    (ram_re),
      .raddr_i (ram_raddr),
      .rdata_o (ram_rdata[g])
    );
  end

  assign out_free  = !ovalid_q || out_o.ready;
  assign pos_inc   = (pos_q < PW'(L)) ? pos_q + PW'(1) : pos_q;
  assign len_c     = (pos_q < PW'(L - 1)) ? pos_q[AW-1:0] : AW'(L - 1);
  assign ram_waddr = pos_q[AW-1:0];

  // Check verdict: first matching entry in table order decides; unlocked, every check is allowed
  always_comb begin
    verdict = ppm_pkg::RES_HIDDEN;
    found   = 1'b0;
    for (int i = 0; i < N; i++) begin
      if (!found && (CW'(i) < count_q) && match_q[i] && (pos_q >= PW'(plen_q[i])) &&
          ((pos_q == PW'(plen_q[i])) || slash_q[i] || eslash_q[i])) begin
        found   = 1'b1;
        verdict = ((perms_q[i] & item_i.bits) == item_i.bits) ?
                  ppm_pkg::RES_ALLOW : ppm_pkg::RES_DENY;
      end
    end
    if (!locked_q) begin
      verdict = ppm_pkg::RES_ALLOW;
    end
  end

  // Sequence one queued item at a time
  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    locked_d      = locked_q;
    pos_d         = pos_q;
    match_d       = match_q;
    slash_d       = slash_q;
    ch_d          = ch_q;
    perms_in_d    = perms_in_q;
    len_d         = len_q;
    pop_o         = 1'b0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_raddr     = pos_q[AW-1:0];
    emit          = 1'b0;
    emit_kind     = ppm_pkg::KIND_UNVEIL;
    emit_code     = ppm_pkg::RES_ADDED;
    commit        = 1'b0;
    commit_eslash = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          unique case (item_i.cls)
            ppm_pkg::CLS_CLEAR: begin
              pop_o    = 1'b1;
              count_d  = '0;
              locked_d = 1'b0;
              pos_d    = '0;
              match_d  = '1;
              slash_d  = '0;
            end
            ppm_pkg::CLS_LOCK: begin
              pop_o    = 1'b1;
              locked_d = 1'b1;
              pos_d    = '0;
              match_d  = '1;
              slash_d  = '0;
            end
            ppm_pkg::CLS_UBYTE: begin
              pop_o  = 1'b1;
              ram_we = !locked_q && (count_q < CW'(N)) && (pos_q < PW'(L - 1));
              pos_d  = pos_inc;
            end
            ppm_pkg::CLS_CBYTE: begin
              pop_o   = 1'b1;
              ram_re  = 1'b1;
              ch_d    = item_i.ch;
              state_d = ST_CHK;
            end
            ppm_pkg::CLS_UTERM: begin
              if (locked_q || (count_q >= CW'(N)) || (len_c == '0)) begin
                if (out_free) begin
                  pop_o     = 1'b1;
                  emit      = 1'b1;
                  emit_kind = ppm_pkg::KIND_UNVEIL;
                  if (locked_q) begin
                    emit_code = ppm_pkg::RES_LOCKED;
                  end else if (count_q >= CW'(N)) begin
                    emit_code = ppm_pkg::RES_FULL;
                  end else begin
                    emit_code = ppm_pkg::RES_ADDED;
                    commit    = 1'b1;
                    count_d   = count_q + CW'(1);
                  end
                  len_d      = len_c;
                  perms_in_d = item_i.bits;
                  pos_d      = '0;
                  match_d    = '1;
                  slash_d    = '0;
                end
              end else begin
                // Fetch the last prefix byte to see if it is a slash
                pop_o      = 1'b1;
                ram_re     = 1'b1;
                ram_raddr  = len_c - AW'(1);
                len_d      = len_c;
                perms_in_d = item_i.bits;
                state_d    = ST_TERM;
              end
            end
            default: begin
              if (out_free) begin
                pop_o     = 1'b1;
                emit      = 1'b1;
                emit_kind = ppm_pkg::KIND_CHECK;
                emit_code = verdict;
                pos_d     = '0;
                match_d   = '1;
                slash_d   = '0;
              end
            end
          endcase
        end
      end
      ST_CHK: begin
        for (int i = 0; i < N; i++) begin
          if (CW'(i) < count_q) begin
            if (pos_q < PW'(plen_q[i])) begin
              if (ram_rdata[i] != ch_q) begin
                match_d[i] = 1'b0;
              end
            end else if (pos_q == PW'(plen_q[i])) begin
              if (ch_q == ppm_pkg::SLASH) begin
                slash_d[i] = 1'b1;
              end
            end
          end
        end
        pos_d   = pos_inc;
        state_d = ST_IDLE;
      end
      default: begin
        if (out_free) begin
          emit          = 1'b1;
          emit_kind     = ppm_pkg::KIND_UNVEIL;
          emit_code     = ppm_pkg::RES_ADDED;
          commit        = 1'b1;
          commit_eslash = (ram_rdata[count_q[EW-1:0]] == ppm_pkg::SLASH);
          count_d       = count_q + CW'(1);
          pos_d         = '0;
          match_d       = '1;
          slash_d       = '0;
          state_d       = ST_IDLE;
        end
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      locked_q <= 1'b0;
      pos_q    <= '0;
      match_q  <= '1;
      slash_q  <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      locked_q <= locked_d;
      pos_q    <= pos_d;
      match_q  <= match_d;
      slash_q  <= slash_d;
      ovalid_q <= emit ? 1'b1 : (out_o.ready ? 1'b0 : ovalid_q);
    end
  end

  // Payload registers and table entries
  always_ff @(posedge clk_i) begin
    ch_q       <= ch_d;
    perms_in_q <= perms_in_d;
    len_q      <= len_d;
    if (emit) begin
      okind_q <= emit_kind;
      ocode_q <= emit_code;
    end
    if (commit) begin
      plen_q[count_q[EW-1:0]]   <= (state_q == ST_IDLE) ? len_c : len_q;
      perms_q[count_q[EW-1:0]]  <= (state_q == ST_IDLE) ? item_i.bits : perms_in_q;
      eslash_q[count_q[EW-1:0]] <= commit_eslash;
    end
  end

  assign out_o.valid = ovalid_q;
  assign out_o.kind  = okind_q;
  assign out_o.code  = ocode_q;

endmodule
